### hw/rtl/udp_frame_receive_filter_core_defines.svh
// Assertion macros for the UDP receive filter.
`ifndef UDP_FRAME_RECEIVE_FILTER_CORE_DEFINES_SVH
`define UDP_FRAME_RECEIVE_FILTER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define UFRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udp receive filter check failed");
// Next-cycle implication, disabled during reset.
`define UFRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udp receive filter check failed");
`else
`define UFRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define UFRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/ufrf_pkg.sv
package ufrf_pkg;

   localparam int MAC_WIDTH   = 48;
   localparam int OUT_COUNT_W = 11;
   localparam int LIMIT_WIDTH = 11;
   localparam int POS_WIDTH   = 6;

   localparam logic [MAC_WIDTH-1:0]   OWN_MAC_RESET = 48'hC860_009F_0ADD;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET   = 11'd1500;
   localparam logic [MAC_WIDTH-1:0]   MAC_ALL_ONES  = {MAC_WIDTH{1'b1}};

   // Header byte offsets and expected values
   localparam logic [POS_WIDTH-1:0] POS_SRC_START  = 6'd6;
   localparam logic [POS_WIDTH-1:0] POS_SRC_LAST   = 6'd11;
   localparam logic [POS_WIDTH-1:0] POS_TYPE_HI    = 6'd12;
   localparam logic [POS_WIDTH-1:0] POS_TYPE_LO    = 6'd13;
   localparam logic [POS_WIDTH-1:0] POS_PROTOCOL   = 6'd23;
   localparam logic [POS_WIDTH-1:0] POS_HDR_LAST   = 6'd41;
   localparam logic [POS_WIDTH-1:0] PAYLOAD_START  = 6'd42;

   localparam logic [7:0] ETHERTYPE_HI = 8'h08;
   localparam logic [7:0] ETHERTYPE_LO = 8'h00;
   localparam logic [7:0] PROTO_UDP    = 8'h11;

   // Register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OWN_MAC       = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_LIMIT = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             payload_byte;
      logic                   has_byte;
      logic                   payload_last;
      logic [MAC_WIDTH-1:0]   dest_mac;
      logic [MAC_WIDTH-1:0]   src_mac;
      logic [OUT_COUNT_W-1:0] payload_count;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } filt_result_type;

endpackage

### hw/rtl/udp_frame_receive_filter_core.sv
// UDP receive filter: takes an Ethernet frame one request byte per clock and
// forwards the UDP payload (bytes 42 on) of frames that are IPv4 (ethertype
// 08 00), UDP (protocol 0x11), not sent by this station and addressed to this
// station or to broadcast. Each result carries the byte, both captured MACs
// and a running count; the byte that reaches payload_limit is marked last and
// the rest of that frame is dropped. A kept frame that ends right after the
// header gives one empty result marked last; shorter frames give nothing.
// Throughput is one byte per clock while req_ready is high: the parser updates
// its state and forms the result in the cycle a byte is accepted, and the
// result sits in a single output register in the next cycle. req_ready stays
// high while the output register is empty or drained in the same cycle. The
// user must write own_mac and payload_limit through the csr port only while
// idle (not enforced by the block); MAC check uses own_mac at header byte 11.
module udp_frame_receive_filter_core #(
   parameter int COUNT_WIDTH = 11
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ufrf_pkg::req_payload_type               req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ufrf_pkg::rsp_payload_type               rsp_payload,
   input  logic                                    csr_we,
   input  logic [ufrf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ufrf_pkg::MAC_WIDTH-1:0]          csr_wdata
);
   import ufrf_pkg::*;
   `include "udp_frame_receive_filter_core_defines.svh"

   logic [MAC_WIDTH-1:0]   own_mac_ff;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic                   accept;
   filt_result_type        result;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= OWN_MAC_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_MAC:       own_mac_ff <= csr_wdata;
            CSR_PAYLOAD_LIMIT: limit_ff   <= csr_wdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The output register frees up in the same cycle it is drained
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   ufrf_filter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_filter (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_payload   (req_payload),
      .own_mac       (own_mac_ff),
      .payload_limit (limit_ff),
      .result        (result)
   );

   ufrf_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Empty result only marks the end of a header-only frame
   `UFRF_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid && !rsp_payload.has_byte, rsp_payload.payload_last && rsp_payload.payload_count == '0)
   // Payload count never goes past the limit in effect
   `UFRF_ASSERT_IMPLY(a_count_in_limit, clock, reset, rsp_valid && rsp_payload.has_byte, rsp_payload.payload_count != '0 && rsp_payload.payload_count <= limit_ff)
   // A new result is only produced when the output register can take it
   `UFRF_ASSERT_NEXT(a_result_lands, clock, reset, result.valid, rsp_valid && rsp_payload == $past(result.payload))

endmodule

### hw/rtl/ufrf_filter.sv
module ufrf_filter #(
   parameter int COUNT_WIDTH = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  ufrf_pkg::req_payload_type            req_payload,
   input  logic [ufrf_pkg::MAC_WIDTH-1:0]       own_mac,
   input  logic [ufrf_pkg::LIMIT_WIDTH-1:0]     payload_limit,
   output ufrf_pkg::filt_result_type            result
);
   import ufrf_pkg::*;

   localparam int LimW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam logic [LimW-1:0] CountMax = LimW'((1 << COUNT_WIDTH) - 1);

   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [MAC_WIDTH-1:0]   dest_ff, dest_in;
   logic [MAC_WIDTH-1:0]   src_ff, src_in;
   logic                   ok_ff, ok_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   lim_hit_ff, lim_hit_in;

   logic [7:0]      b;
   logic            last;
   logic            in_header;
   logic            ok_hdr;
   logic [LimW-1:0] lim_wide;
   logic [LimW-1:0] lim;
   logic [LimW-1:0] cnt_next;
   logic            hdr_emit;
   logic            pay_emit;
   logic            at_limit;

   assign b         = req_payload.frame_byte;
   assign last      = req_payload.frame_last;
   assign in_header = (pos_ff < PAYLOAD_START);

   // Effective limit is capped to what the counter can hold
   assign lim_wide = LimW'(payload_limit);
   assign lim      = (lim_wide > CountMax) ? CountMax : lim_wide;
   assign cnt_next = LimW'(cnt_ff) + LimW'(1);
   assign at_limit = (cnt_next == lim);

   always_comb begin
      dest_in = dest_ff;
      src_in  = src_ff;
      if (in_header && pos_ff < POS_SRC_START) begin
         dest_in = {dest_ff[MAC_WIDTH-9:0], b};
      end
      if (in_header && pos_ff >= POS_SRC_START && pos_ff <= POS_SRC_LAST) begin
         src_in = {src_ff[MAC_WIDTH-9:0], b};
      end
   end

   always_comb begin
      ok_hdr = ok_ff;
      if (pos_ff == POS_TYPE_HI && b != ETHERTYPE_HI) ok_hdr = 1'b0;
      if (pos_ff == POS_TYPE_LO && b != ETHERTYPE_LO) ok_hdr = 1'b0;
      if (pos_ff == POS_PROTOCOL && b != PROTO_UDP) ok_hdr = 1'b0;
      if (pos_ff == POS_SRC_LAST) begin
         if (src_in == own_mac) ok_hdr = 1'b0;
         if (dest_ff != MAC_ALL_ONES && dest_ff != own_mac) ok_hdr = 1'b0;
      end
   end

   assign hdr_emit = in_header && last && (pos_ff == POS_HDR_LAST) && ok_hdr;
   assign pay_emit = !in_header && ok_ff && !lim_hit_ff && (LimW'(cnt_ff) < lim);

   always_comb begin
      result.valid                 = accept && (hdr_emit || pay_emit);
      result.payload.dest_mac      = dest_in;
      result.payload.src_mac       = src_in;
      result.payload.payload_byte  = pay_emit ? b : 8'd0;
      result.payload.has_byte      = pay_emit;
      result.payload.payload_last  = hdr_emit || at_limit || last;
      result.payload.payload_count = pay_emit ? cnt_next[OUT_COUNT_W-1:0] : '0;
   end

   always_comb begin
      pos_in     = pos_ff;
      ok_in      = ok_ff;
      cnt_in     = cnt_ff;
      lim_hit_in = lim_hit_ff;
      if (in_header) begin
         pos_in = pos_ff + POS_WIDTH'(1);
         ok_in  = ok_hdr;
      end else if (pay_emit) begin
         cnt_in = cnt_next[COUNT_WIDTH-1:0];
         if (at_limit) lim_hit_in = 1'b1;
      end
      if (last) begin
         pos_in     = '0;
         ok_in      = 1'b1;
         cnt_in     = '0;
         lim_hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         dest_ff    <= '0;
         src_ff     <= '0;
         ok_ff      <= 1'b1;
         cnt_ff     <= '0;
         lim_hit_ff <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
         ok_ff      <= ok_in;
         cnt_ff     <= cnt_in;
         lim_hit_ff <= lim_hit_in;
      end
   end

endmodule

### hw/rtl/ufrf_out_reg.sv
module ufrf_out_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  ufrf_pkg::filt_result_type   result,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ufrf_pkg::rsp_payload_type   rsp_payload
);
   import ufrf_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   always_comb begin
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         data_ff <= result.payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ufrf_pkg::*;

   typedef logic [7:0] octet_queue_type[$];

   localparam int DRAIN_CYCLES = 8;      // output register plus margin
   localparam int HOLD_CYCLES  = 300;    // long receiver stall for the fill-up test
   localparam int PHASE_ITEMS  = 50;     // random requests per idling phase

   // ---------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_OWN_MAC;
   logic [MAC_WIDTH-1:0]       csr_wdata = '0;

   always #1 clock = ~clock;

   udp_frame_receive_filter_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Idle rates in percent of cycles, set per phase by the test sequence
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;

   // ---------------------------------------------------------------
   // Filter model: registers and per-frame parse state
   // ---------------------------------------------------------------
   logic [MAC_WIDTH-1:0]   own_mac_cfg = OWN_MAC_RESET;
   logic [LIMIT_WIDTH-1:0] limit_cfg   = LIMIT_RESET;
   logic [POS_WIDTH-1:0]   hdr_pos     = '0;     // stops counting at PAYLOAD_START
   logic [MAC_WIDTH-1:0]   cap_dest    = '0;
   logic [MAC_WIDTH-1:0]   cap_src     = '0;
   logic                   frame_keep  = 1'b1;
   logic [OUT_COUNT_W-1:0] fwd_count   = '0;
   logic                   fwd_capped  = 1'b0;

   rsp_payload_type        pending_payloads[$];

   // Advances the model by one accepted request byte. Returns 1 when the
   // byte produces a response, which is written to fwd.
   // The limit is 11 bits wide, so the count-width cap never bites here.
   function automatic bit predict_payload(input req_payload_type rq,
                                          output rsp_payload_type fwd);
      logic [POS_WIDTH-1:0]   pos;
      logic [OUT_COUNT_W-1:0] next_count;
      bit                     at_limit;
      bit                     produced;
      pos      = hdr_pos;
      produced = 1'b0;
      fwd      = '0;
      if (pos < PAYLOAD_START) begin
         if (pos < POS_SRC_START)
            cap_dest = {cap_dest[MAC_WIDTH-9:0], rq.frame_byte};
         else if (pos <= POS_SRC_LAST)
            cap_src = {cap_src[MAC_WIDTH-9:0], rq.frame_byte};
         else if (pos == POS_TYPE_HI && rq.frame_byte != ETHERTYPE_HI)
            frame_keep = 1'b0;
         else if (pos == POS_TYPE_LO && rq.frame_byte != ETHERTYPE_LO)
            frame_keep = 1'b0;
         else if (pos == POS_PROTOCOL && rq.frame_byte != PROTO_UDP)
            frame_keep = 1'b0;
         // address filter runs once both MACs are complete
         if (pos == POS_SRC_LAST) begin
            if (cap_src == own_mac_cfg)
               frame_keep = 1'b0;
            if (cap_dest != MAC_ALL_ONES && cap_dest != own_mac_cfg)
               frame_keep = 1'b0;
         end
         // kept frame ending right after the header: empty response
         if (rq.frame_last && pos == POS_HDR_LAST && frame_keep) begin
            fwd.payload_last = 1'b1;
            fwd.dest_mac     = cap_dest;
            fwd.src_mac      = cap_src;
            produced         = 1'b1;
         end
         hdr_pos = pos + 1'b1;
      end else if (frame_keep && !fwd_capped && fwd_count < limit_cfg) begin
         next_count = fwd_count + 1'b1;
         at_limit   = (next_count == limit_cfg);
         fwd_count  = next_count;
         if (at_limit)
            fwd_capped = 1'b1;
         fwd.payload_byte  = rq.frame_byte;
         fwd.has_byte      = 1'b1;
         fwd.payload_last  = at_limit || rq.frame_last;
         fwd.dest_mac      = cap_dest;
         fwd.src_mac       = cap_src;
         fwd.payload_count = next_count;
         produced          = 1'b1;
      end
      // MACs survive the frame boundary, everything else restarts
      if (rq.frame_last) begin
         hdr_pos    = '0;
         frame_keep = 1'b1;
         fwd_count  = '0;
         fwd_capped = 1'b0;
      end
      return produced;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Monitor: tracks csr writes and accepted requests in the model,
   // then checks each accepted response against the oldest prediction.
   // Everything is sampled at the clock edge, before NBA updates.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_MAC:       own_mac_cfg = csr_wdata;
               CSR_PAYLOAD_LIMIT: limit_cfg   = csr_wdata[LIMIT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (predict_payload(req_payload, want))
               pending_payloads = {pending_payloads, want};
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_payloads.size() == 0) begin
               $error("unexpected response: byte 0x%0h count %0d",
                      rsp_payload.payload_byte, rsp_payload.payload_count);
               error_count++;
            end else begin
               want = pending_payloads.pop_front();
               check_field("payload_byte",  want.payload_byte,  rsp_payload.payload_byte);
               check_field("has_byte",      want.has_byte,      rsp_payload.has_byte);
               check_field("payload_last",  want.payload_last,  rsp_payload.payload_last);
               check_field("dest_mac",      want.dest_mac,      rsp_payload.dest_mac);
               check_field("src_mac",       want.src_mac,       rsp_payload.src_mac);
               check_field("payload_count", want.payload_count, rsp_payload.payload_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request.
   // The hold length is counted here; the test only bumps hold_token.
   // ---------------------------------------------------------------
   int hold_token = 0;

   always @(posedge clock) begin : rsp_stall
      int hold_seen;
      int hold_left;
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Valid is left high after acceptance; it only drops when an idle
   // cycle is drawn, so it is never lowered and raised in one step.
   task automatic send_frame_byte(input logic [7:0] value, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{frame_byte: value, frame_last: is_last};
      @(posedge clock);
      while (!(req_valid && req_ready))
         @(posedge clock);
   endtask

   task automatic send_frame(input octet_queue_type octets, input bit mark_last);
      int i;
      for (i = 0; i < octets.size(); i++)
         send_frame_byte(octets[i], mark_last && (i == octets.size() - 1));
   endtask

   // Drain: nothing outstanding, then a DRAIN_CYCLES wait for a dropped byte
   // that may still be in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_payloads.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr writes only happen with the block drained
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [MAC_WIDTH-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [MAC_WIDTH-1:0] rand_mac();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic octet_queue_type build_header(input logic [MAC_WIDTH-1:0] dest,
                                                    input logic [MAC_WIDTH-1:0] src,
                                                    input logic [7:0] type_hi,
                                                    input logic [7:0] type_lo,
                                                    input logic [7:0] proto);
      octet_queue_type hdr;
      int              i;
      for (i = 0; i < 6; i++)
         hdr = {hdr, dest[MAC_WIDTH-1-8*i -: 8]};
      for (i = 0; i < 6; i++)
         hdr = {hdr, src[MAC_WIDTH-1-8*i -: 8]};
      hdr = {hdr, type_hi};
      hdr = {hdr, type_lo};
      for (i = POS_TYPE_LO + 1; i < PAYLOAD_START; i++)
         hdr = {hdr, (i == POS_PROTOCOL) ? proto : 8'($urandom())};
      return hdr;
   endfunction

   function automatic void append_random(ref octet_queue_type octets, input int count);
      int i;
      for (i = 0; i < count; i++)
         octets = {octets, 8'($urandom())};
   endfunction

   // Well-formed UDP header with the given addresses
   function automatic octet_queue_type well_formed_header(input logic [MAC_WIDTH-1:0] dest,
                                                          input logic [MAC_WIDTH-1:0] src);
      return build_header(dest, src, ETHERTYPE_HI, ETHERTYPE_LO, PROTO_UDP);
   endfunction

   // ---------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------
   // Unicast and broadcast frames with payload extremes
   task automatic test_kept_frames();
      octet_queue_type f;
      f = well_formed_header(own_mac_cfg, 48'h0000_0000_0000);
      f = {f, 8'h00};
      f = {f, 8'hFF};
      f = {f, 8'h5A};
      send_frame(f, 1'b1);
      f = well_formed_header(MAC_ALL_ONES, MAC_ALL_ONES - 1);
      f = {f, 8'hFF};
      send_frame(f, 1'b1);
   endtask

   // Each filter condition failing on its own
   task automatic test_rejected_frames();
      octet_queue_type f;
      f = well_formed_header(48'h0200_0000_0001, 48'h0200_0000_0002);   // foreign dest
      append_random(f, 2);
      send_frame(f, 1'b1);
      f = well_formed_header(MAC_ALL_ONES, own_mac_cfg);                 // own source
      append_random(f, 2);
      send_frame(f, 1'b1);
      f = build_header(own_mac_cfg, 48'h1, 8'h86, ETHERTYPE_LO, PROTO_UDP);
      append_random(f, 2);
      send_frame(f, 1'b1);
      f = build_header(own_mac_cfg, 48'h1, ETHERTYPE_HI, 8'h06, PROTO_UDP);
      append_random(f, 2);
      send_frame(f, 1'b1);
      f = build_header(own_mac_cfg, 48'h1, ETHERTYPE_HI, ETHERTYPE_LO, 8'h06);
      append_random(f, 2);
      send_frame(f, 1'b1);
   endtask

   // Header-only frames (kept and not) and frames cut short
   task automatic test_header_only_and_short();
      octet_queue_type f;
      f = well_formed_header(own_mac_cfg, 48'h0A0B_0C0D_0E0F);
      send_frame(f, 1'b1);
      f = well_formed_header(48'h0200_0000_0009, 48'h0A0B_0C0D_0E0F);
      send_frame(f, 1'b1);
      f = well_formed_header(own_mac_cfg, 48'h0A0B_0C0D_0E0F);
      send_frame(f[0:POS_HDR_LAST-1], 1'b1);                     // ends at byte 40
      send_frame(f[0:0], 1'b1);
      send_frame(f[0:POS_SRC_LAST], 1'b1);
      // a normal frame right after shows the parser restarted
      f = well_formed_header(own_mac_cfg, 48'h0A0B_0C0D_0E0F);
      append_random(f, 2);
      send_frame(f, 1'b1);
   endtask

   // Limit reached mid-frame drops the rest, including frame_last
   task automatic test_payload_limit();
      octet_queue_type f;
      write_csr(CSR_PAYLOAD_LIMIT, 48'd3);
      f = well_formed_header(MAC_ALL_ONES, 48'h1);
      append_random(f, 6);
      send_frame(f, 1'b1);
      write_csr(CSR_PAYLOAD_LIMIT, 48'd1);
      f = well_formed_header(MAC_ALL_ONES, 48'h1);
      append_random(f, 2);
      send_frame(f, 1'b1);
      // zero limit: no payload at all, but the empty header response remains
      write_csr(CSR_PAYLOAD_LIMIT, 48'd0);
      f = well_formed_header(MAC_ALL_ONES, 48'h1);
      append_random(f, 3);
      send_frame(f, 1'b1);
      f = well_formed_header(MAC_ALL_ONES, 48'h1);
      send_frame(f, 1'b1);
      write_csr(CSR_PAYLOAD_LIMIT, LIMIT_RESET);
   endtask

   // Limit lowered below the count mid-frame: rest dropped, no last mark
   task automatic test_limit_lowered_midframe();
      octet_queue_type f;
      f = well_formed_header(own_mac_cfg, 48'h1234_5678_9ABC);
      append_random(f, 5);
      send_frame(f, 1'b0);
      write_csr(CSR_PAYLOAD_LIMIT, 48'd2);
      f.delete();
      append_random(f, 3);
      send_frame(f, 1'b1);
      write_csr(CSR_PAYLOAD_LIMIT, LIMIT_RESET);
      f = well_formed_header(own_mac_cfg, 48'h1234_5678_9ABC);
      append_random(f, 2);
      send_frame(f, 1'b1);
   endtask

   // own_mac rewritten after the dest bytes but before byte 11
   task automatic test_mac_change_midframe();
      octet_queue_type f;
      f = well_formed_header(48'h0200_00C0_FFEE, 48'h0200_0000_0077);
      append_random(f, 3);
      send_frame(f[0:POS_SRC_START-1], 1'b0);
      write_csr(CSR_OWN_MAC, 48'h0200_00C0_FFEE);
      send_frame(f[POS_SRC_START:$], 1'b1);
      write_csr(CSR_OWN_MAC, OWN_MAC_RESET);
   endtask

   // Receiver holds off while requests keep coming: the output register
   // fills and req_ready has to drop until the stall ends.
   task automatic test_backpressure();
      octet_queue_type f;
      write_csr(CSR_PAYLOAD_LIMIT, LIMIT_RESET);
      hold_token++;
      f = well_formed_header(MAC_ALL_ONES, own_mac_cfg ^ 48'h1);
      append_random(f, 20);
      send_frame(f, 1'b1);
   endtask

   // ---------------------------------------------------------------
   // Random traffic: mostly well-formed frames with random content,
   // the rest broken headers, truncated frames and plain noise.
   // ---------------------------------------------------------------
   task automatic test_random_traffic(input int n_items);
      octet_queue_type      f;
      int                   sent;
      int                   kind;
      int                   cut_len;
      logic [MAC_WIDTH-1:0] dest;
      logic [MAC_WIDTH-1:0] src;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         dest = (kind < 45) ? own_mac_cfg : MAC_ALL_ONES;
         src  = rand_mac();
         if (src == own_mac_cfg)
            src = src ^ 48'h1;
         if (kind >= 80 && kind < 85)
            dest = rand_mac();
         else if (kind >= 85 && kind < 90)
            src = own_mac_cfg;
         f = well_formed_header(dest, src);
         if (kind >= 90 && kind < 95) begin
            case ($urandom_range(3))
               0: f[POS_TYPE_HI]  = f[POS_TYPE_HI]  ^ 8'($urandom_range(1, 255));
               1: f[POS_TYPE_LO]  = f[POS_TYPE_LO]  ^ 8'($urandom_range(1, 255));
               2: f[POS_PROTOCOL] = f[POS_PROTOCOL] ^ 8'($urandom_range(1, 255));
               default: f[$urandom_range(POS_HDR_LAST)] = 8'($urandom());
            endcase
         end
         if (kind >= 95) begin
            f.delete();
            append_random(f, $urandom_range(1, 60));
         end else if ($urandom_range(9) == 0) begin
            cut_len = $urandom_range(1, PAYLOAD_START);
            f = f[0:cut_len-1];
         end else begin
            append_random(f, $urandom_range(0, 24));
         end
         send_frame(f, 1'b1);
         sent += f.size();
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender idles lightly, receiver stalls often
      send_idle_pct = 28;
      recv_idle_pct = 72;
      test_kept_frames();
      test_rejected_frames();
      test_header_only_and_short();
      test_payload_limit();
      test_limit_lowered_midframe();
      test_mac_change_midframe();

      write_csr(CSR_OWN_MAC, rand_mac());
      write_csr(CSR_PAYLOAD_LIMIT, 48'($urandom_range(4, 16)));
      test_random_traffic(PHASE_ITEMS);

      // phase two: roles swapped, extreme register values
      wait_idle();
      send_idle_pct = 72;
      recv_idle_pct = 28;
      write_csr(CSR_OWN_MAC, MAC_ALL_ONES);
      write_csr(CSR_PAYLOAD_LIMIT, 48'd2047);
      test_random_traffic(PHASE_ITEMS);

      // phase three: full rate on both sides
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_OWN_MAC, 48'h0);
      test_backpressure();
      write_csr(CSR_PAYLOAD_LIMIT, 48'($urandom_range(1, 20)));
      test_random_traffic(PHASE_ITEMS);

      wait_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ufrf_pkg.sv
hw/rtl/ufrf_filter.sv
hw/rtl/ufrf_out_reg.sv
hw/rtl/udp_frame_receive_filter_core.sv
verif/tb_top.sv
